// ----- design/ghe_pkg.sv -----
`timescale 1ns / 1ps

package ghe_pkg;

  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int LEVEL_W   = 8;
  localparam int COUNT_W   = 24;
  localparam int DIM_W     = 13;
  localparam int DIV_W     = 2 * DIM_W;
  localparam int FRAC_W    = 16;
  localparam int VALUE_W   = FRAC_W + 1;
  localparam int STEP_W    = $clog2(FRAC_W);
  localparam int CMP_W     = ((BIN_W > LEVEL_W) ? BIN_W : LEVEL_W) + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [VALUE_W-1:0] Q16_ONE   = VALUE_W'(1) << FRAC_W;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CNT_WR = 5'b00010,
    S_SCAN   = 5'b00100,
    S_MAP_RD = 5'b01000,
    S_DIV    = 5'b10000
  } state_t;

  // Levels beyond the last bin fold into it.
  function automatic logic [BIN_W-1:0] bin_index(input logic [LEVEL_W-1:0] level);
    logic [CMP_W-1:0] lev;
    lev = CMP_W'(level);
    if (lev >= CMP_W'(NUM_BINS - 1)) begin
      return BIN_W'(NUM_BINS - 1);
    end
    return BIN_W'(lev);
  endfunction

endpackage

// ----- design/global_histogram_equalizer_unit.sv -----
`timescale 1ns / 1ps
// Count item: read, then write back through the bin store; with frame_end, S_SCAN then walks
// the store to form the cumulative sum, one bin a cycle. Map item: result in the cycle after
// the transfer if not finalised, via S_MAP_RD if the count reaches the divisor, else via
// S_MAP_RD and S_DIV (store read plus a 16-step restoring divider); clear and unused modes
// stay idle, no done; busy is high while an item is in work, done strobes a result.
// rst (synchronous) empties the store at once through per-bin valid bits, no clearing pass.

module global_histogram_equalizer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode,
  input  logic [ghe_pkg::LEVEL_W-1:0]    pixel_level,
  input  logic                           frame_end,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [ghe_pkg::DIM_W-1:0]      cfg_data,
  output logic                           done,
  output logic [ghe_pkg::VALUE_W-1:0]    equalized_value,
  output logic                           not_finalized
);

  ghe_pkg::state_t state;

  logic [ghe_pkg::DIM_W-1:0]    image_width;
  logic [ghe_pkg::DIM_W-1:0]    image_height;
  logic [ghe_pkg::DIV_W-1:0]    divisor;

  logic [ghe_pkg::NUM_BINS-1:0] bin_valid;
  logic                         cumulative_ready;

  logic [ghe_pkg::BIN_W-1:0]    idx_q;
  logic                         last_q;
  logic                         rd_valid;

  logic [ghe_pkg::BIN_W:0]      scan_rd;
  logic                         pv;
  logic [ghe_pkg::BIN_W-1:0]    pa;
  logic [ghe_pkg::COUNT_W-1:0]  run;

  logic [ghe_pkg::DIV_W-1:0]    rem;
  logic [ghe_pkg::FRAC_W-1:0]   quot;
  logic [ghe_pkg::STEP_W-1:0]   step;

  logic                         accept;
  logic [ghe_pkg::BIN_W-1:0]    in_idx;
  logic                         new_frame;

  logic                         ram_we;
  logic [ghe_pkg::BIN_W-1:0]    ram_waddr;
  logic [ghe_pkg::COUNT_W-1:0]  ram_wdata;
  logic [ghe_pkg::BIN_W-1:0]    ram_raddr;
  logic [ghe_pkg::COUNT_W-1:0]  ram_rdata;

  logic [ghe_pkg::COUNT_W-1:0]  rd_count;
  logic [ghe_pkg::COUNT_W-1:0]  inc_count;
  logic [ghe_pkg::COUNT_W-1:0]  scan_in;
  logic [ghe_pkg::COUNT_W:0]    scan_sum;
  logic [ghe_pkg::COUNT_W-1:0]  run_next;
  logic                         scan_issue;
  logic [ghe_pkg::DIV_W:0]      rem_shift;
  logic                         q_bit;
  logic [ghe_pkg::DIV_W-1:0]    rem_next;
  logic [ghe_pkg::FRAC_W-1:0]   quot_next;

  assign busy      = (state != ghe_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign in_idx    = ghe_pkg::bin_index(pixel_level);
  assign new_frame = cumulative_ready && (mode == ghe_pkg::MODE_COUNT);

  // Stale or cleared bins read as zero.
  assign rd_count  = rd_valid ? ram_rdata : '0;
  assign inc_count = (rd_count == ghe_pkg::COUNT_MAX) ? rd_count
                                                      : rd_count + ghe_pkg::COUNT_W'(1);

  assign scan_in   = (pv && rd_valid) ? ram_rdata : '0;
  assign scan_sum  = {1'b0, run} + {1'b0, scan_in};
  assign run_next  = scan_sum[ghe_pkg::COUNT_W] ? ghe_pkg::COUNT_MAX
                                                : scan_sum[ghe_pkg::COUNT_W-1:0];
  assign scan_issue = (state == ghe_pkg::S_SCAN) && !scan_rd[ghe_pkg::BIN_W];

  assign rem_shift = {rem, 1'b0};
  assign q_bit     = (rem_shift >= {1'b0, divisor});
  assign rem_next  = q_bit ? ghe_pkg::DIV_W'(rem_shift - {1'b0, divisor})
                           : ghe_pkg::DIV_W'(rem_shift);
  assign quot_next = {quot[ghe_pkg::FRAC_W-2:0], q_bit};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = inc_count;
    ram_raddr = in_idx;
    unique case (state)
      ghe_pkg::S_CNT_WR: begin
        ram_we = 1'b1;
      end
      ghe_pkg::S_SCAN: begin
        ram_raddr = scan_rd[ghe_pkg::BIN_W-1:0];
        ram_we    = pv;
        ram_waddr = pa;
        ram_wdata = run_next;
      end
      default: begin
      end
    endcase
  end

  ghe_ram #(
    .WIDTH (ghe_pkg::COUNT_W),
    .DEPTH (ghe_pkg::NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    divisor <= ghe_pkg::DIV_W'(image_width) * ghe_pkg::DIV_W'(image_height);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ghe_pkg::WIDTH_RESET;
      image_height <= ghe_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ghe_pkg::REG_WIDTH:  image_width  <= cfg_data;
        ghe_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ghe_pkg::S_IDLE;
      bin_valid        <= '0;
      cumulative_ready <= 1'b0;
      done             <= 1'b0;
      pv               <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ghe_pkg::S_IDLE: begin
          if (accept) begin
            idx_q    <= in_idx;
            last_q   <= frame_end;
            rd_valid <= bin_valid[in_idx] && !new_frame;
            case (mode)
              ghe_pkg::MODE_COUNT: begin
                if (cumulative_ready) begin
                  bin_valid        <= '0;
                  cumulative_ready <= 1'b0;
                end
                state <= ghe_pkg::S_CNT_WR;
              end
              ghe_pkg::MODE_MAP: begin
                if (cumulative_ready) begin
                  state <= ghe_pkg::S_MAP_RD;
                end else begin
                  done            <= 1'b1;
                  equalized_value <= '0;
                  not_finalized   <= 1'b1;
                end
              end
              ghe_pkg::MODE_CLEAR: begin
                bin_valid        <= '0;
                cumulative_ready <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ghe_pkg::S_CNT_WR: begin
          bin_valid[idx_q] <= 1'b1;
          if (last_q) begin
            scan_rd <= '0;
            pv      <= 1'b0;
            run     <= '0;
            state   <= ghe_pkg::S_SCAN;
          end else begin
            state <= ghe_pkg::S_IDLE;
          end
        end
        ghe_pkg::S_SCAN: begin
          // Read bin i while bin i-1 is summed and written back.
          pv <= scan_issue;
          if (scan_issue) begin
            pa       <= scan_rd[ghe_pkg::BIN_W-1:0];
            rd_valid <= bin_valid[scan_rd[ghe_pkg::BIN_W-1:0]];
            scan_rd  <= scan_rd + (ghe_pkg::BIN_W+1)'(1);
          end
          if (pv) begin
            run           <= run_next;
            bin_valid[pa] <= 1'b1;
            if (pa == ghe_pkg::BIN_W'(ghe_pkg::NUM_BINS - 1)) begin
              cumulative_ready <= 1'b1;
              state            <= ghe_pkg::S_IDLE;
            end
          end
        end
        ghe_pkg::S_MAP_RD: begin
          // A count at or above the divisor saturates to one.
          if (divisor == '0 || ghe_pkg::DIV_W'(rd_count) >= divisor) begin
            done            <= 1'b1;
            equalized_value <= ghe_pkg::Q16_ONE;
            not_finalized   <= 1'b0;
            state           <= ghe_pkg::S_IDLE;
          end else begin
            rem   <= ghe_pkg::DIV_W'(rd_count);
            quot  <= '0;
            step  <= '0;
            state <= ghe_pkg::S_DIV;
          end
        end
        ghe_pkg::S_DIV: begin
          rem  <= rem_next;
          quot <= quot_next;
          step <= step + ghe_pkg::STEP_W'(1);
          if (step == ghe_pkg::STEP_W'(ghe_pkg::FRAC_W - 1)) begin
            done            <= 1'b1;
            equalized_value <= {1'b0, quot_next};
            not_finalized   <= 1'b0;
            state           <= ghe_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ghe_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/ghe_ram.sv -----
`timescale 1ns / 1ps

module ghe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
